/* src/dsi_pkg.sv */
// ----------------------------------------------------------------------------
// dsi_pkg
// Types and constants for the decimal string to signed integer parser.
// ----------------------------------------------------------------------------
package dsi_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SPACE,
		PH_SIGNED,
		PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_DIGITS    = 2'd1,
		ST_OUT_OF_RANGE = 2'd2,
		ST_INVALID_BASE = 2'd3
	} status_t;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	localparam logic [5:0] BASE_DECIMAL = 6'd10;

	localparam int OUT_VALUE_BITS = 64;
	localparam int OUT_COUNT_BITS = 16;

endpackage

/* src/decimal_string_to_signed_integer.sv */
// ----------------------------------------------------------------------------
// decimal_string_to_signed_integer
// Parses a base-10 signed integer from a character stream, one byte a word.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one character a word: s_tdata is the byte (0 ends the
//   string), s_tuser high marks the first character of a new conversion and
//   abandons any conversion in progress. Leading whitespace is skipped, one
//   '+' or '-' is taken, then digits accumulate until a non-digit, NUL or
//   overflow ends the number. Each conversion gives one result word on m_*;
//   later characters are dropped until the next start.
//   cfg_* writes the radix; any value other than 10 makes the next start
//   report invalid base. It is sampled at the start character.
// Timing:
//   One character is taken every cycle while no result is held. A word
//   passes an input register and a result register. The digit step
//   (multiply by ten as shift and add, plus the limit compare) sits
//   between those two registers.
// Reset and stall:
//   arst_n clears the parser to idle and the radix to 10. While m_tready is
//   low a result is held; the input register still takes a word if it is
//   empty, then s_tready drops.
// ----------------------------------------------------------------------------
module decimal_string_to_signed_integer #(
	parameter int VALUE_BITS = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: number_base
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_byte
	input  logic        s_tuser,  // [0] first_char
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata   // [63:0] parsed_value, [65:64] status_code,
	                              // [81:66] consumed_count, [87:82] zero
);

	localparam logic [VALUE_BITS-1:0] LIM_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] LIM_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] TOP_POS = VALUE_BITS'(LIM_POS / 10);
	localparam logic [VALUE_BITS-1:0] TOP_NEG = VALUE_BITS'(LIM_NEG / 10);
	localparam logic [3:0]            LAST_POS = 4'(LIM_POS % 10);
	localparam logic [3:0]            LAST_NEG = 4'(LIM_NEG % 10);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// input register
	logic       valid_s1;
	logic       first_s1;
	logic [7:0] char_s1;

	// parser state
	dsi_pkg::phase_t         phase_q;
	logic                    neg_q;
	logic [VALUE_BITS-1:0]   mag_q;
	logic [COUNT_BITS-1:0]   pos_q;
	logic [COUNT_BITS-1:0]   eo_q;
	logic [5:0]              base_q;

	// result register
	logic                             out_valid_q;
	logic [dsi_pkg::OUT_VALUE_BITS-1:0] out_value_q;
	dsi_pkg::status_t                 out_status_q;
	logic [dsi_pkg::OUT_COUNT_BITS-1:0] out_count_q;

	logic advance;
	logic step;

	// next state
	dsi_pkg::phase_t         phase_d;
	logic                    neg_d;
	logic [VALUE_BITS-1:0]   mag_d;
	logic [COUNT_BITS-1:0]   pos_d;
	logic [COUNT_BITS-1:0]   eo_d;
	logic                    emit;
	dsi_pkg::status_t        res_status;
	logic [VALUE_BITS-1:0]   res_mag;
	logic [COUNT_BITS-1:0]   res_count;

	logic                    is_space;
	logic                    is_digit;
	logic [3:0]              digit;
	logic [VALUE_BITS+3:0]   mag_x10;
	logic signed [VALUE_BITS-1:0] res_signed;
	logic [31:0]             res_count_w;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || m_tready;
	assign step      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;

	assign is_space = (char_s1 == dsi_pkg::CHAR_SPACE) ||
		(char_s1 >= dsi_pkg::CHAR_TAB && char_s1 <= dsi_pkg::CHAR_CR);
	assign is_digit = (char_s1 >= dsi_pkg::CHAR_ZERO) && (char_s1 <= dsi_pkg::CHAR_NINE);
	assign digit    = char_s1[3:0];

	always_comb begin
		dsi_pkg::phase_t       ph;
		logic                  neg;
		logic [VALUE_BITS-1:0] mag;
		logic [COUNT_BITS-1:0] pos;
		logic [COUNT_BITS-1:0] eo;
		logic [VALUE_BITS-1:0] top;
		logic [VALUE_BITS-1:0] lim;
		logic [3:0]            last;

		ph         = phase_q;
		neg        = neg_q;
		mag        = mag_q;
		pos        = pos_q;
		eo         = eo_q;
		emit       = 1'b0;
		res_status = dsi_pkg::ST_OK;
		res_mag    = '0;
		res_count  = '0;
		mag_x10    = '0;

		if (first_s1) begin
			neg = 1'b0;
			mag = '0;
			pos = '0;
			eo  = '0;
			ph  = dsi_pkg::PH_SPACE;
			if (base_q != dsi_pkg::BASE_DECIMAL) begin
				ph         = dsi_pkg::PH_IDLE;
				emit       = 1'b1;
				res_status = dsi_pkg::ST_INVALID_BASE;
			end
		end

		top  = neg ? TOP_NEG : TOP_POS;
		lim  = neg ? LIM_NEG : LIM_POS;
		last = neg ? LAST_NEG : LAST_POS;

		unique case (ph)
			dsi_pkg::PH_IDLE: begin
			end
			dsi_pkg::PH_SPACE: begin
				if (is_space) begin
					if (pos != COUNT_MAX) pos = pos + COUNT_BITS'(1);
				end else if (char_s1 == dsi_pkg::CHAR_PLUS || char_s1 == dsi_pkg::CHAR_MINUS) begin
					neg = (char_s1 == dsi_pkg::CHAR_MINUS);
					if (pos != COUNT_MAX) pos = pos + COUNT_BITS'(1);
					ph = dsi_pkg::PH_SIGNED;
				end else if (!is_digit) begin
					emit       = 1'b1;
					res_status = dsi_pkg::ST_NO_DIGITS;
					ph         = dsi_pkg::PH_IDLE;
				end
			end
			dsi_pkg::PH_SIGNED: begin
				if (!is_digit) begin
					emit       = 1'b1;
					res_status = dsi_pkg::ST_OK;
					ph         = dsi_pkg::PH_IDLE;
				end
			end
			dsi_pkg::PH_DIGITS: begin
				if (!is_digit) begin
					emit       = 1'b1;
					res_status = dsi_pkg::ST_OK;
					res_mag    = mag;
					res_count  = eo;
					ph         = dsi_pkg::PH_IDLE;
				end
			end
			default: begin
				ph = dsi_pkg::PH_IDLE;
			end
		endcase

		// digit step shared by the space, sign and digit phases
		if (is_digit && !emit && ph != dsi_pkg::PH_IDLE) begin
			if (mag > top || (mag == top && digit > last)) begin
				mag        = lim;
				emit       = 1'b1;
				res_status = dsi_pkg::ST_OUT_OF_RANGE;
				res_mag    = lim;
				res_count  = eo;
				ph         = dsi_pkg::PH_IDLE;
			end else begin
				mag_x10 = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} +
					(VALUE_BITS+4)'(digit);
				mag     = mag_x10[VALUE_BITS-1:0];
				if (pos != COUNT_MAX) pos = pos + COUNT_BITS'(1);
				eo = pos;
				ph = dsi_pkg::PH_DIGITS;
			end
		end

		phase_d = ph;
		neg_d   = neg;
		mag_d   = mag;
		pos_d   = pos;
		eo_d    = eo;
	end

	assign res_signed  = neg_d ? signed'(VALUE_BITS'(-res_mag)) : signed'(res_mag);
	assign res_count_w = 32'(res_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			first_s1 <= s_tuser;
			char_s1  <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dsi_pkg::PH_IDLE;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			pos_q   <= '0;
			eo_q    <= '0;
			base_q  <= dsi_pkg::BASE_DECIMAL;
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			if (step) begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				mag_q   <= mag_d;
				pos_q   <= pos_d;
				eo_q    <= eo_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_value_q  <= dsi_pkg::OUT_VALUE_BITS'(res_signed);
			out_status_q <= res_status;
			out_count_q  <= (res_count_w > 32'h0000_FFFF) ? 16'hFFFF : res_count_w[15:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_count_q, out_status_q, out_value_q};

endmodule

/* tb/tb_decimal_string_to_signed_integer.sv */
// ----------------------------------------------------------------------------
// tb_decimal_string_to_signed_integer
// Self-checking bench for the base-10 string to signed integer parser.
// Characters go in one word at a time with random gaps. Each one is fed to
// a predictor of the parse, and every result word is checked against the
// oldest expected conversion, predicted or from a fixed table row. The
// radix register is rewritten between phases. Random strings run close to
// both 64-bit limits. A long receiver stall backs the pipe up.
// ----------------------------------------------------------------------------
module tb_decimal_string_to_signed_integer;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0]      value;
		dsi_pkg::status_t status;
		logic [15:0]      count;
	} parse_result_t;

	typedef struct packed {
		logic          st;
		logic [7:0]    c;
		logic          typed;
		parse_result_t want;
	} char_row_t;

	localparam logic [63:0] TEN       = 64'd10;
	localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
	localparam logic [15:0] POS_MAX   = 16'hFFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = 6'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;

	decimal_string_to_signed_integer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser state as predicted
	dsi_pkg::phase_t ph = dsi_pkg::PH_IDLE;
	logic          neg_seen = 1'b0;
	logic [63:0]   mag_acc = 64'd0;
	logic [15:0]   char_pos = 16'd0;
	logic [15:0]   digits_end = 16'd0;
	logic [5:0]    base_reg = dsi_pkg::BASE_DECIMAL;
	logic          conv_done;
	parse_result_t conv_res;

	parse_result_t conversion_q[$];
	char_row_t     char_rows[$];
	int            mismatches = 0;
	int            busy_items = 0;
	bit            calm = 1'b0;
	bit            hold_req = 1'b0;
	bit            hold_done = 1'b0;
	bit            opening;
	string         lim_digits = "922337203685477580";

	function automatic char_row_t mk_row(logic st, logic [7:0] c, logic typed,
			logic [63:0] v, dsi_pkg::status_t s, logic [15:0] n);
		char_row_t r;
		r.st = st;
		r.c = c;
		r.typed = typed;
		r.want.value = v;
		r.want.status = s;
		r.want.count = n;
		return r;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= dsi_pkg::CHAR_ZERO && c <= dsi_pkg::CHAR_NINE;
	endfunction

	task automatic close_conversion(logic [63:0] v, dsi_pkg::status_t s, logic [15:0] n);
		conv_done = 1'b1;
		conv_res.value = v;
		conv_res.status = s;
		conv_res.count = n;
		ph = dsi_pkg::PH_IDLE;
	endtask

	task automatic bump_pos();
		if (char_pos != POS_MAX)
			char_pos = char_pos + 16'd1;
	endtask

	task automatic accumulate_digit(logic [7:0] c);
		logic [63:0] limit;
		logic [63:0] top;
		logic [63:0] last;
		logic [63:0] d;
		limit = neg_seen ? NEG_LIMIT : POS_LIMIT;
		top = limit / TEN;
		last = limit % TEN;
		d = {56'd0, c - dsi_pkg::CHAR_ZERO};
		if (mag_acc > top || (mag_acc == top && d > last)) begin
			mag_acc = limit;
			close_conversion(neg_seen ? 64'd0 - mag_acc : mag_acc,
				dsi_pkg::ST_OUT_OF_RANGE, digits_end);
		end else begin
			mag_acc = mag_acc * TEN + d;
			bump_pos();
			digits_end = char_pos;
			ph = dsi_pkg::PH_DIGITS;
		end
	endtask

	task automatic predict_char(logic st, logic [7:0] c);
		conv_done = 1'b0;
		if (st) begin
			neg_seen = 1'b0;
			mag_acc = 64'd0;
			char_pos = 16'd0;
			digits_end = 16'd0;
			if (base_reg != dsi_pkg::BASE_DECIMAL) begin
				close_conversion(64'd0, dsi_pkg::ST_INVALID_BASE, 16'd0);
				return;
			end
			ph = dsi_pkg::PH_SPACE;
		end else if (ph == dsi_pkg::PH_IDLE) begin
			return;
		end
		case (ph)
			dsi_pkg::PH_SPACE: begin
				if (c == dsi_pkg::CHAR_SPACE ||
						(c >= dsi_pkg::CHAR_TAB && c <= dsi_pkg::CHAR_CR)) begin
					bump_pos();
				end else if (c == dsi_pkg::CHAR_PLUS || c == dsi_pkg::CHAR_MINUS) begin
					neg_seen = (c == dsi_pkg::CHAR_MINUS);
					bump_pos();
					ph = dsi_pkg::PH_SIGNED;
				end else if (is_digit(c)) begin
					accumulate_digit(c);
				end else begin
					close_conversion(64'd0, dsi_pkg::ST_NO_DIGITS, 16'd0);
				end
			end
			dsi_pkg::PH_SIGNED: begin
				if (is_digit(c))
					accumulate_digit(c);
				else
					close_conversion(64'd0, dsi_pkg::ST_OK, 16'd0);
			end
			dsi_pkg::PH_DIGITS: begin
				if (is_digit(c))
					accumulate_digit(c);
				else
					close_conversion(neg_seen ? 64'd0 - mag_acc : mag_acc, dsi_pkg::ST_OK,
						digits_end);
			end
			default: ph = dsi_pkg::PH_IDLE;
		endcase
	endtask

	// Offer one character word; predict it once it is taken.
	task automatic send_char(logic st, logic [7:0] c, logic typed, parse_result_t want);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= st;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		busy_items++;
		predict_char(st, c);
		if (typed)
			conversion_q.push_back(want);
		else if (conv_done)
			conversion_q.push_back(conv_res);
	endtask

	task automatic put_char(logic [7:0] c);
		send_char(opening, c, 1'b0, '0);
		opening = 1'b0;
	endtask

	task automatic send_number();
		int n;
		int mode;
		int term;
		logic [7:0] c;
		opening = 1'b1;
		n = $urandom_range(0, 3);
		repeat (n)
			put_char($urandom_range(0, 3) == 0 ? dsi_pkg::CHAR_SPACE :
				8'($urandom_range(9, 13)));
		case ($urandom_range(0, 2))
			1: put_char(dsi_pkg::CHAR_PLUS);
			2: put_char(dsi_pkg::CHAR_MINUS);
			default: ;
		endcase
		mode = $urandom_range(0, 3);
		case (mode)
			0: begin
				n = $urandom_range(0, 6);
				repeat (n) put_char(dsi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
			1: begin
				// walk up to the limit, then vary the last digit
				for (int i = 0; i < 18; i++)
					put_char(lim_digits[i]);
				put_char(dsi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 3) == 0)
					put_char(dsi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
			2: begin
				n = $urandom_range(17, 21);
				put_char(dsi_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
				repeat (n - 1) put_char(dsi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
			default: begin
				n = $urandom_range(1, 22);
				repeat (n) put_char(dsi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
		endcase
		term = $urandom_range(0, 2);
		if (term == 0) begin
			put_char(8'h00);
		end else if (term == 1) begin
			do c = 8'($urandom_range(0, 255)); while (is_digit(c));
			put_char(c);
		end
		n = $urandom_range(0, 2);
		repeat (n) put_char(8'($urandom_range(0, 255)));
	endtask

	task automatic run_random(int n);
		int target;
		int k;
		target = busy_items + n;
		while (busy_items < target) begin
			if ($urandom_range(99) < 20) begin
				k = $urandom_range(1, 3);
				repeat (k)
					send_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						1'b0, '0);
			end else begin
				send_number();
			end
		end
	endtask

	// Drain the parser, then write the radix.
	task automatic write_base(logic [5:0] v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (conversion_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		base_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver side
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (80) @(negedge clk);
			end
			m_tready <= calm || $urandom_range(99) >= 14;
		end
	end

	always @(posedge clk) begin : check_results
		parse_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (conversion_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result word: %h", m_tdata);
				mismatches++;
			end else begin
				want = conversion_q.pop_front();
				if (m_tdata[63:0] !== want.value || m_tdata[65:64] !== want.status ||
						m_tdata[81:66] !== want.count) begin
					if (mismatches < 10)
						$display("mismatch: value %0d/%0d status %0d/%0d count %0d/%0d (exp/act)",
							$signed(want.value), $signed(m_tdata[63:0]), want.status,
							m_tdata[65:64], want.count, m_tdata[81:66]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("tb_decimal_string_to_signed_integer: errors");
		$finish;
	end

	initial begin
		char_rows.push_back(mk_row(1'b0, "5", 1'b0, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b1, 8'h00, 1'b1, 64'd0, dsi_pkg::ST_NO_DIGITS, 16'd0));
		char_rows.push_back(mk_row(1'b1, dsi_pkg::CHAR_PLUS, 1'b0, 64'd0, dsi_pkg::ST_OK,
			16'd0));
		char_rows.push_back(mk_row(1'b0, 8'h00, 1'b1, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b1, dsi_pkg::CHAR_SPACE, 1'b0, 64'd0, dsi_pkg::ST_OK,
			16'd0));
		char_rows.push_back(mk_row(1'b0, dsi_pkg::CHAR_TAB, 1'b0, 64'd0, dsi_pkg::ST_OK,
			16'd0));
		char_rows.push_back(mk_row(1'b0, dsi_pkg::CHAR_MINUS, 1'b0, 64'd0, dsi_pkg::ST_OK,
			16'd0));
		char_rows.push_back(mk_row(1'b0, "4", 1'b0, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b0, "2", 1'b0, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b0, "x", 1'b0, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b0, "7", 1'b0, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b1, 8'hFF, 1'b1, 64'd0, dsi_pkg::ST_NO_DIGITS, 16'd0));
		char_rows.push_back(mk_row(1'b1, "1", 1'b0, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b0, "2", 1'b0, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b1, "9", 1'b0, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b0, 8'h00, 1'b0, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b1, dsi_pkg::CHAR_CR, 1'b0, 64'd0, dsi_pkg::ST_OK,
			16'd0));
		char_rows.push_back(mk_row(1'b0, dsi_pkg::CHAR_ZERO, 1'b0, 64'd0, dsi_pkg::ST_OK,
			16'd0));
		char_rows.push_back(mk_row(1'b0, 8'h00, 1'b0, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b1, dsi_pkg::CHAR_MINUS, 1'b0, 64'd0, dsi_pkg::ST_OK,
			16'd0));
		char_rows.push_back(mk_row(1'b0, "a", 1'b1, 64'd0, dsi_pkg::ST_OK, 16'd0));
		char_rows.push_back(mk_row(1'b1, "a", 1'b1, 64'd0, dsi_pkg::ST_NO_DIGITS, 16'd0));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (char_rows[i])
			send_char(char_rows[i].st, char_rows[i].c, char_rows[i].typed,
				char_rows[i].want);

		write_base(6'd0);
		run_random(25);
		write_base(6'd63);
		run_random(25);
		write_base(6'd36);
		run_random(25);
		write_base(dsi_pkg::BASE_DECIMAL);
		run_random(130);
		calm = 1'b1;
		run_random(90);
		calm = 1'b0;
		hold_req = 1'b1;
		run_random(100);
		write_base(6'd11);
		run_random(25);
		write_base(dsi_pkg::BASE_DECIMAL);
		run_random(60);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (conversion_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_decimal_string_to_signed_integer: clean");
		else
			$display("tb_decimal_string_to_signed_integer: errors");
		$finish;
	end

endmodule

/* decimal_string_to_signed_integer.f */
src/dsi_pkg.sv
src/decimal_string_to_signed_integer.sv
tb/tb_decimal_string_to_signed_integer.sv
